// ----- src/separable_box_sum_filter_top_assert.svh -----
// Assertion macros used by the separable box-sum filter top level.
`ifndef SEPARABLE_BOX_SUM_FILTER_TOP_ASSERT_SVH
`define SEPARABLE_BOX_SUM_FILTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BSF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define BSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSF_ASSERT_SAME(lbl, ante, cons, msg)
`define BSF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/bsf_pkg.sv -----
// Shared types, constants and width helpers for the box-sum filter.
`timescale 1ns / 1ps
package bsf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 7;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int PIX_FIELD_W = 16;
    localparam int SUM_FIELD_W = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_R_W     = 3;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [CFG_R_W-1:0]    RADIUS_RST = 3'd1;
    localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 11'd1024;

    typedef struct packed {
        logic                   req_type;
        logic [PIX_FIELD_W-1:0] pixel;
    } bsf_in_t;

    typedef struct packed {
        logic [SUM_FIELD_W-1:0] box_sum;
        logic                   frame_end;
    } bsf_out_t;

    // Vertical stage controls for one column step.
    typedef struct packed {
        logic add;
        logic sub;
        logic base_zero;
    } bsf_vctl_t;

    // Horizontal stage controls for one column step.
    typedef struct packed {
        logic v_step;
        logic emit;
        logic tail_out;
        logic vc_zero;
        logic vc_last;
        logic in_leave;
        logic tail_leave;
        logic frame_end;
    } bsf_hctl_t;

    typedef struct packed {
        logic at_start;
        logic in_done;
    } bsf_stat_t;

    function automatic int pix_width(input int pixel_bits);
        return (pixel_bits < PIX_FIELD_W) ? pixel_bits : PIX_FIELD_W;
    endfunction

    function automatic int col_sum_width(input int pixel_bits, input int max_radius);
        return pix_width(pixel_bits) + $clog2(2 * max_radius + 1);
    endfunction

endpackage

// ----- src/bsf_ctrl.sv -----
// Configuration registers, frame position counters and per-step control decode.
`timescale 1ns / 1ps
module bsf_ctrl
    import bsf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    input  logic [CFG_IDX_W-1:0]                    cfg_index,
    input  logic [CFG_DATA_W-1:0]                   cfg_wdata,
    input  logic                                    accept,
    input  logic                                    req_type,
    output logic                                    step_valid,
    output logic [$clog2(MAX_WIDTH)-1:0]            step_col,
    output logic [$clog2(2*MAX_RADIUS+2)-1:0]       wr_slot,
    output logic [$clog2(2*MAX_RADIUS+2)-1:0]       rd_slot,
    output logic [$clog2(2*MAX_RADIUS+1)-1:0]       tap_sel,
    output bsf_vctl_t                               vctl,
    output bsf_hctl_t                               hctl,
    output bsf_stat_t                               status
);

    localparam int TAPS   = 2 * MAX_RADIUS + 1;
    localparam int LINES  = TAPS + 1;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int SR_W   = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
    localparam int SLOT_W = $clog2(LINES);
    localparam int TAP_W  = $clog2(TAPS);
    localparam int CW     = ((W_W > SR_W) ? W_W : SR_W) + 2;

    logic [CFG_R_W-1:0]    radius_reg, radius_next;
    logic [CFG_DATA_W-1:0] width_reg, width_next;
    logic [CFG_DATA_W-1:0] height_reg, height_next;
    logic [SR_W-1:0]       sr_reg, sr_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  in_done_reg, in_done_next;

    logic [CW-1:0]     eff_w, eff_h, eff_r, two_r1, sr_x, col_x;
    logic [SLOT_W:0]   rd_sum;
    logic              pix_step, drn_step, col_last, fend, cfg_hit;

    always_comb begin
        if (width_reg == '0) begin
            eff_w = CW'(1);
        end else if (CW'(width_reg) > CW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(width_reg);
        end
        if (height_reg == '0) begin
            eff_h = CW'(1);
        end else if (CW'(height_reg) > CW'(MAX_HEIGHT)) begin
            eff_h = CW'(MAX_HEIGHT);
        end else begin
            eff_h = CW'(height_reg);
        end
        eff_r = CW'(radius_reg);
        if (eff_r > CW'(MAX_RADIUS)) eff_r = CW'(MAX_RADIUS);
        if (eff_r > eff_w - 1'b1) eff_r = eff_w - 1'b1;
        if (eff_r > eff_h - 1'b1) eff_r = eff_h - 1'b1;
    end

    assign two_r1   = (eff_r << 1) + 1'b1;
    assign sr_x     = CW'(sr_reg);
    assign col_x    = CW'(col_reg);
    assign col_last = (col_x == eff_w - 1'b1);
    assign pix_step = accept && (req_type == REQ_PIXEL) && !in_done_reg;
    assign drn_step = accept && (req_type == REQ_DRAIN) && in_done_reg;

    // With a nonzero radius the frame closes on the last horizontal tail step,
    // which follows the final column sweep by radius steps.
    assign fend = (eff_r == '0) ? ((sr_x == eff_h - 1'b1) && col_last)
                                : ((sr_x == eff_h + eff_r) && (col_x == eff_r - 1'b1));

    assign step_valid = pix_step || drn_step;
    assign step_col   = col_reg;
    assign wr_slot    = slot_reg;
    assign rd_sum     = (SLOT_W+1)'(slot_reg) + (SLOT_W+1)'(LINES) - (SLOT_W+1)'(two_r1);
    assign rd_slot    = (rd_sum >= (SLOT_W+1)'(LINES)) ? SLOT_W'(rd_sum - (SLOT_W+1)'(LINES))
                                                       : SLOT_W'(rd_sum);
    assign tap_sel    = TAP_W'(eff_r << 1);

    assign vctl.add       = pix_step;
    assign vctl.sub       = (sr_x >= two_r1);
    assign vctl.base_zero = (sr_x == '0);

    assign hctl.v_step     = (sr_x >= eff_r);
    assign hctl.emit       = (sr_x >= eff_r) && ((col_x >= eff_r) || (sr_x > eff_r));
    assign hctl.tail_out   = (col_x < eff_r);
    assign hctl.vc_zero    = (col_x == '0);
    assign hctl.vc_last    = col_last;
    assign hctl.in_leave   = (col_x >= two_r1);
    assign hctl.tail_leave = ((col_x + eff_w) >= two_r1);
    assign hctl.frame_end  = fend;

    assign status.at_start = (sr_reg == '0) && (col_reg == '0);
    assign status.in_done  = in_done_reg;

    assign cfg_hit = cfg_valid && ((cfg_index == CFG_RADIUS) || (cfg_index == CFG_WIDTH) ||
                                   (cfg_index == CFG_HEIGHT));

    always_comb begin
        radius_next  = radius_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        sr_next      = sr_reg;
        col_next     = col_reg;
        slot_next    = slot_reg;
        in_done_next = in_done_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_RADIUS: radius_next = cfg_wdata[CFG_R_W-1:0];
                CFG_WIDTH:  width_next  = cfg_wdata;
                CFG_HEIGHT: height_next = cfg_wdata;
                default:    ;
            endcase
        end
        if (cfg_hit || (step_valid && fend)) begin
            sr_next      = '0;
            col_next     = '0;
            slot_next    = '0;
            in_done_next = 1'b0;
        end else if (step_valid) begin
            if (col_last) begin
                col_next  = '0;
                sr_next   = SR_W'(sr_x + 1'b1);
                slot_next = (slot_reg == SLOT_W'(LINES - 1)) ? '0 : slot_reg + 1'b1;
            end else begin
                col_next = COL_W'(col_x + 1'b1);
            end
            if (pix_step && (sr_x == eff_h - 1'b1) && col_last) begin
                in_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= RADIUS_RST;
            width_reg   <= WIDTH_RST;
            height_reg  <= HEIGHT_RST;
            sr_reg      <= '0;
            col_reg     <= '0;
            slot_reg    <= '0;
            in_done_reg <= 1'b0;
        end else begin
            radius_reg  <= radius_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            sr_reg      <= sr_next;
            col_reg     <= col_next;
            slot_reg    <= slot_next;
            in_done_reg <= in_done_next;
        end
    end

endmodule

// ----- src/bsf_vert.sv -----
// Line memory of raw pixels and column-sum memory with the vertical running-sum update.
`timescale 1ns / 1ps
module bsf_vert
    import bsf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                adv,
    input  logic                                                step_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]                        step_col,
    input  logic [$clog2(2*MAX_RADIUS+2)-1:0]                   wr_slot,
    input  logic [$clog2(2*MAX_RADIUS+2)-1:0]                   rd_slot,
    input  logic [pix_width(PIXEL_BITS)-1:0]                    pixel,
    input  bsf_vctl_t                                           vctl,
    input  bsf_hctl_t                                           hctl,
    output logic                                                s2_valid,
    output logic [col_sum_width(PIXEL_BITS, MAX_RADIUS)-1:0]    s2_v,
    output bsf_hctl_t                                           s2_hctl
);

    localparam int LINES  = 2 * MAX_RADIUS + 2;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int PIX_W  = pix_width(PIXEL_BITS);
    localparam int CS_W   = col_sum_width(PIXEL_BITS, MAX_RADIUS);
    localparam int ADDR_W = $clog2(LINES * MAX_WIDTH);

    logic [PIX_W-1:0] pix_mem [LINES*MAX_WIDTH];
    logic [CS_W-1:0]  cs_mem [MAX_WIDTH];

    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [PIX_W-1:0]  pix_rd_reg, s1_pix_reg;
    logic [CS_W-1:0]   cs_rd_reg, last_v_reg, s2_v_reg;
    logic [COL_W-1:0]  s1_col_reg, last_col_reg;
    logic              s1_valid_reg, last_valid_reg, s2_valid_reg;
    bsf_vctl_t         s1_vctl_reg;
    bsf_hctl_t         s1_hctl_reg, s2_hctl_reg;
    logic [CS_W-1:0]   base, v_new;

    assign wr_addr = ADDR_W'(wr_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(step_col);
    assign rd_addr = ADDR_W'(rd_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(step_col);

    always_ff @(posedge aclk) begin
        if (adv && step_valid) begin
            if (vctl.add) begin
                pix_mem[wr_addr] <= pixel;
            end
            pix_rd_reg <= pix_mem[rd_addr];
        end
    end

    // The column read and the write-back of the step ahead meet at one entry
    // only on a one-pixel-wide frame; the last written value is forwarded then.
    always_ff @(posedge aclk) begin
        if (adv && step_valid) begin
            cs_rd_reg <= cs_mem[step_col];
        end
        if (adv && s1_valid_reg) begin
            cs_mem[s1_col_reg] <= v_new;
        end
    end

    always_comb begin
        if (s1_vctl_reg.base_zero) begin
            base = '0;
        end else if (last_valid_reg && (last_col_reg == s1_col_reg)) begin
            base = last_v_reg;
        end else begin
            base = cs_rd_reg;
        end
        v_new = base + (s1_vctl_reg.add ? CS_W'(s1_pix_reg) : '0)
                     - (s1_vctl_reg.sub ? CS_W'(pix_rd_reg) : '0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_col_reg  <= step_col;
            s1_pix_reg  <= pixel;
            s1_vctl_reg <= vctl;
            s1_hctl_reg <= hctl;
            s2_v_reg    <= v_new;
            s2_hctl_reg <= s1_hctl_reg;
            if (s1_valid_reg) begin
                last_col_reg <= s1_col_reg;
                last_v_reg   <= v_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            last_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= step_valid;
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg) begin
                last_valid_reg <= 1'b1;
            end
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_v     = s2_v_reg;
    assign s2_hctl  = s2_hctl_reg;

endmodule

// ----- src/bsf_horiz.sv -----
// Horizontal running sum over column sums, row tail handling and result register.
`timescale 1ns / 1ps
module bsf_horiz
    import bsf_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                m_ready,
    input  logic                                                s2_valid,
    input  logic [col_sum_width(PIXEL_BITS, MAX_RADIUS)-1:0]    s2_v,
    input  bsf_hctl_t                                           s2_hctl,
    input  logic [$clog2(2*MAX_RADIUS+1)-1:0]                   tap_sel,
    output logic                                                adv,
    output logic                                                m_valid,
    output bsf_out_t                                            m_data
);

    localparam int TAPS  = 2 * MAX_RADIUS + 1;
    localparam int CS_W  = col_sum_width(PIXEL_BITS, MAX_RADIUS);
    localparam int HS_W  = CS_W + $clog2(TAPS);
    localparam int EXT_W = (HS_W > SUM_FIELD_W) ? HS_W : SUM_FIELD_W;

    logic [CS_W-1:0] hist_reg [TAPS];
    logic [HS_W-1:0] s_reg, t_reg;
    logic            m_valid_reg;
    bsf_out_t        m_data_reg;

    logic [HS_W-1:0] leave, s_new, t_new, res;
    logic [EXT_W-1:0] res_x;

    // The column sum that leaves the window is always the one taken 2R+1 steps
    // ago, both inside a row and for the tail of the row before.
    assign leave = HS_W'(hist_reg[tap_sel]);
    assign s_new = s2_hctl.vc_zero ? HS_W'(s2_v)
                                   : s_reg + HS_W'(s2_v) - (s2_hctl.in_leave ? leave : '0);
    assign t_new = t_reg - (s2_hctl.tail_leave ? leave : '0);
    assign res   = s2_hctl.tail_out ? t_new : s_new;
    assign res_x = EXT_W'(res);
    assign adv   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (adv && s2_valid && s2_hctl.v_step) begin
            hist_reg[0] <= s2_v;
            for (int i = 1; i < TAPS; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
            s_reg <= s_new;
            if (s2_hctl.vc_last) begin
                t_reg <= s_new;
            end else if (s2_hctl.tail_out) begin
                t_reg <= t_new;
            end
        end
        if (adv) begin
            m_data_reg.box_sum   <= res_x[SUM_FIELD_W-1:0];
            m_data_reg.frame_end <= s2_hctl.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= s2_valid && s2_hctl.emit;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- src/separable_box_sum_filter_top.sv -----
// Top level of the streaming separable box-sum filter.
//
//   channel  direction  handshake                  payload
//   s_       in         s_valid / s_ready          bsf_in_t  (req_type, pixel)
//   m_       out        m_valid / m_ready          bsf_out_t (box_sum, frame_end)
//   cfg_     in         cfg_valid / cfg_ready      cfg_index, cfg_wdata
//
// One transaction is taken per clock unless the pipe holds; a result reaches m_data
// through the memory read, vertical update and horizontal update registers.
// The rate is set by the column-sum memory, read and written once per column step.
// When the result register is full and m_ready is low the whole pipe holds and
// s_ready drops. Reset is synchronous on aresetn low and needs no memory sweep:
// column sums restart from zero on the first row of each frame.
`timescale 1ns / 1ps
`include "separable_box_sum_filter_top_assert.svh"
module separable_box_sum_filter_top
    import bsf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bsf_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bsf_out_t              m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int LINES = 2 * MAX_RADIUS + 2;
    localparam int TAPS  = 2 * MAX_RADIUS + 1;
    localparam int PIX_W = pix_width(PIXEL_BITS);
    localparam int CS_W  = col_sum_width(PIXEL_BITS, MAX_RADIUS);

    logic                         adv, accept, step_valid, s2_valid;
    logic [$clog2(MAX_WIDTH)-1:0] step_col;
    logic [$clog2(LINES)-1:0]     wr_slot, rd_slot;
    logic [$clog2(TAPS)-1:0]      tap_sel;
    logic [CS_W-1:0]              s2_v;
    bsf_vctl_t                    vctl;
    bsf_hctl_t                    hctl, s2_hctl;
    bsf_stat_t                    status;
    logic                         cfg_write;

    assign s_ready   = adv;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && adv;
    assign cfg_write = cfg_valid && cfg_ready && ((cfg_index == CFG_RADIUS) ||
                       (cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT));

    bsf_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .req_type   (s_data.req_type),
        .step_valid (step_valid),
        .step_col   (step_col),
        .wr_slot    (wr_slot),
        .rd_slot    (rd_slot),
        .tap_sel    (tap_sel),
        .vctl       (vctl),
        .hctl       (hctl),
        .status     (status)
    );

    bsf_vert #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_vert (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .step_valid (step_valid),
        .step_col   (step_col),
        .wr_slot    (wr_slot),
        .rd_slot    (rd_slot),
        .pixel      (s_data.pixel[PIX_W-1:0]),
        .vctl       (vctl),
        .hctl       (hctl),
        .s2_valid   (s2_valid),
        .s2_v       (s2_v),
        .s2_hctl    (s2_hctl)
    );

    bsf_horiz #(
        .MAX_RADIUS (MAX_RADIUS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_horiz (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .m_ready  (m_ready),
        .s2_valid (s2_valid),
        .s2_v     (s2_v),
        .s2_hctl  (s2_hctl),
        .tap_sel  (tap_sel),
        .adv      (adv),
        .m_valid  (m_valid),
        .m_data   (m_data)
    );

    `BSF_ASSERT_SAME(a_full_stall_blocks_input, m_valid && !m_ready, !s_ready, "input taken in stall")
    `BSF_ASSERT_NEXT(a_cfg_restarts_frame, cfg_write, status.at_start && !status.in_done, "no restart")
    `BSF_ASSERT_SAME(a_drain_needs_full_frame, accept && !status.in_done, !drn_ok(), "early drain")

    function automatic logic drn_ok();
        return (s_data.req_type == REQ_DRAIN) && step_valid;
    endfunction

endmodule

// ----- bench/tb_separable_box_sum_filter_top.sv -----
// Self-checking testbench for the streaming separable box-sum filter.
`timescale 1ns / 1ps
module tb_separable_box_sum_filter_top;
    import bsf_pkg::*;

    localparam int MAXW = DEF_MAX_WIDTH;
    localparam int MAXH = DEF_MAX_HEIGHT;
    localparam int MAXR = DEF_MAX_RADIUS;
    localparam int TAPS = 2 * MAXR + 1;
    localparam int RING = 2 * MAXR + 2;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    bsf_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    bsf_out_t              m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    separable_box_sum_filter_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Shadow of the filter state.
    logic [15:0] recent_pix [TAPS];
    int          row_acc;
    int          line_sums [RING * MAXW];
    int          pix_in;
    int          sum_out;
    int          radius_reg;
    int          width_reg;
    int          height_reg;

    bsf_out_t    pending_sums [$];
    int          mismatches;
    int          sent_items;
    bit          calm;

    function automatic int frame_w();
        return (width_reg < 1) ? 1 : (width_reg > MAXW) ? MAXW : width_reg;
    endfunction

    function automatic int frame_h();
        return (height_reg < 1) ? 1 : (height_reg > MAXH) ? MAXH : height_reg;
    endfunction

    function automatic int frame_r();
        int r;
        r = radius_reg;
        if (r > MAXR) r = MAXR;
        if (r > frame_w() - 1) r = frame_w() - 1;
        if (r > frame_h() - 1) r = frame_h() - 1;
        return r;
    endfunction

    function automatic void absorb_pixel(int n, int p, int w, int r);
        int row, col, base, leaving, s;
        row = n / w;
        col = n % w;
        base = (row % RING) * MAXW;
        leaving = 0;
        if (col == 0) row_acc = 0;
        if (col >= 2 * r + 1) leaving = recent_pix[(col - 2 * r - 1) % TAPS];
        row_acc = row_acc + p - leaving;
        recent_pix[col % TAPS] = p[15:0];
        if (col >= r) line_sums[base + col - r] = row_acc;
        if (col == w - 1) begin
            s = row_acc;
            for (int j = w - r; j < w; j++) begin
                if (j >= r + 1) s -= recent_pix[(j - r - 1) % TAPS];
                line_sums[base + j] = s;
            end
        end
    endfunction

    function automatic void emit_window_sum(int w, int h, int r);
        int orow, ocol, lo, hi;
        logic [31:0] acc;
        bsf_out_t res;
        orow = sum_out / w;
        ocol = sum_out % w;
        lo = (orow >= r) ? orow - r : 0;
        hi = orow + r;
        if (hi > h - 1) hi = h - 1;
        acc = 0;
        for (int k = lo; k <= hi; k++) acc += line_sums[(k % RING) * MAXW + ocol];
        sum_out++;
        res.box_sum = acc[SUM_FIELD_W-1:0];
        res.frame_end = (sum_out == w * h);
        pending_sums.push_back(res);
        if (res.frame_end) begin
            pix_in = 0;
            sum_out = 0;
        end
    endfunction

    function automatic void predict_box_sum(bsf_in_t item);
        int w, h, r, total;
        w = frame_w();
        h = frame_h();
        r = frame_r();
        total = w * h;
        if (item.req_type == REQ_PIXEL) begin
            if (pix_in >= total) return;
            absorb_pixel(pix_in, item.pixel, w, r);
            pix_in++;
            if (pix_in - 1 >= r * w + r) emit_window_sum(w, h, r);
        end else if (pix_in == total && sum_out < total) begin
            emit_window_sum(w, h, r);
        end
    endfunction

    // Result side: random back-pressure, comparison against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 24);
            if (m_valid && m_ready) begin
                if (pending_sums.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result sum=%0d end=%0b",
                                 m_data.box_sum, m_data.frame_end);
                end else begin
                    if (m_data.box_sum !== pending_sums[0].box_sum ||
                        m_data.frame_end !== pending_sums[0].frame_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected sum=%0d end=%0b, got sum=%0d end=%0b",
                                     pending_sums[0].box_sum, pending_sums[0].frame_end,
                                     m_data.box_sum, m_data.frame_end);
                    end
                    void'(pending_sums.pop_front());
                end
            end
        end
    end

    task automatic send_item(logic req, logic [15:0] pix);
        while (!calm && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{req_type: req, pixel: pix};
        do @(posedge aclk); while (!s_ready);
        predict_box_sum('{req_type: req, pixel: pix});
        sent_items++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_sums.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_RADIUS) radius_reg = val & 3'h7;
        else if (idx == CFG_WIDTH) width_reg = val;
        else height_reg = val;
        pix_in = 0;
        sum_out = 0;
    endtask

    task automatic set_geometry(int r, int w, int h);
        settle();
        write_reg(CFG_RADIUS, {8'($urandom), 3'(r)});
        write_reg(CFG_WIDTH, w[CFG_DATA_W-1:0]);
        write_reg(CFG_HEIGHT, h[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // One full frame of random pixels, with optional early drains, then drains to the end.
    task automatic run_frame(int noise_pct);
        int total;
        total = frame_w() * frame_h();
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(99) < noise_pct) send_item(REQ_DRAIN, 16'($urandom));
            send_item(REQ_PIXEL, 16'($urandom));
        end
        while (pix_in != 0) send_item(REQ_DRAIN, 16'($urandom));
    endtask

    task automatic test_reset_defaults();
        // Default geometry holds results back for a full row, so only a few pixels go in.
        for (int i = 0; i < 6; i++) send_item(REQ_PIXEL, 16'($urandom));
    endtask

    task automatic test_special_cases();
        set_geometry(1, 5, 4);
        send_item(REQ_PIXEL, 16'hFFFF);
        send_item(REQ_DRAIN, 16'h1234);
        for (int i = 1; i < 20; i++) send_item(REQ_PIXEL, (i % 2) ? 16'h0000 : 16'hFFFF);
        send_item(REQ_PIXEL, 16'hFFFF);
        while (pix_in != 0) send_item(REQ_DRAIN, 16'h0000);
        send_item(REQ_DRAIN, 16'hFFFF);
        // A register write part way into a frame abandons it.
        set_geometry(0, 3, 2);
        send_item(REQ_PIXEL, 16'hFFFF);
        set_geometry(2, 3, 3);
        run_frame(0);
    endtask

    task automatic test_config_extremes();
        set_geometry(7, 8, 9);
        run_frame(5);
        set_geometry(7, 0, 0);
        run_frame(0);
        // Clamped geometries: only the start of each long frame is sent.
        set_geometry(7, 2047, 1);
        for (int i = 0; i < 24; i++) send_item(REQ_PIXEL, 16'hFFFF);
        set_geometry(7, 1, 2047);
        for (int i = 0; i < 24; i++) send_item(REQ_PIXEL, 16'hFFFF);
        // The frame center gets the full window of saturated pixels on the last pixel.
        set_geometry(7, 15, 15);
        for (int i = 0; i < 225; i++) send_item(REQ_PIXEL, 16'hFFFF);
    endtask

    task automatic test_random_frames();
        int start;
        start = sent_items;
        while (sent_items - start < 190) begin
            calm = (sent_items - start > 40) && (sent_items - start < 140);
            set_geometry($urandom_range(7), $urandom_range(12, 1), $urandom_range(12, 1));
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(5, 1))
                    send_item($urandom_range(3) == 0 ? REQ_DRAIN : REQ_PIXEL, 16'($urandom));
            end else begin
                run_frame($urandom_range(3) == 0 ? 10 : 0);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RADIUS;
        cfg_wdata = '0;
        calm = 1'b0;
        mismatches = 0;
        sent_items = 0;
        row_acc = 0;
        pix_in = 0;
        sum_out = 0;
        radius_reg = RADIUS_RST;
        width_reg = WIDTH_RST;
        height_reg = HEIGHT_RST;
        foreach (recent_pix[i]) recent_pix[i] = '0;
        foreach (line_sums[i]) line_sums[i] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_special_cases();
        test_config_extremes();
        test_random_frames();

        settle();
        if (mismatches == 0 && pending_sums.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
